[rtl/mntp_pkg.sv]
// ----------------------------------------------------------------------------
// mntp_pkg
// Shared types and constants for the melody note token parser: status codes,
// character codes, the result beat and the note letter offset lookup.
// ----------------------------------------------------------------------------
package mntp_pkg;

  // result status codes
  localparam logic [1:0] ST_NOTE = 2'd0;
  localparam logic [1:0] ST_BAD  = 2'd1;
  localparam logic [1:0] ST_END  = 2'd2;

  // character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_G   = 8'h47;
  localparam logic [7:0] CH_UP_P   = 8'h50;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CASE_GAP  = 8'h20;

  // limits
  localparam logic [7:0] DUR_MAX    = 8'd128;
  localparam logic [4:0] OCT_MAX    = 5'd16;
  localparam logic [4:0] DOTS_MAX   = 5'd16;
  localparam logic [7:0] PAUSE_SEMI = 8'hFF;
  localparam logic [7:0] SEMIS_OCT  = 8'd12;

  // configuration register indexes
  localparam logic [1:0] CFG_DFLT_DUR = 2'd0;
  localparam logic [1:0] CFG_DFLT_OCT = 2'd1;

  // one result beat
  typedef struct packed {
    logic       valid;
    logic [1:0] status;
    logic [7:0] semitone;
    logic [7:0] note_length;
    logic [4:0] dot_count;
    logic       text_done;
  } mntp_res_t;

  // semitone offset of letters A..G within the octave
  function automatic logic [3:0] letter_offset(input logic [2:0] idx);
    logic [3:0] off;
    case (idx)
      3'd0:    off = 4'd9;
      3'd1:    off = 4'd11;
      3'd2:    off = 4'd0;
      3'd3:    off = 4'd2;
      3'd4:    off = 4'd4;
      3'd5:    off = 4'd5;
      3'd6:    off = 4'd7;
      default: off = 4'd9;
    endcase
    return off;
  endfunction

endpackage

[rtl/mntp_step.sv]
// ----------------------------------------------------------------------------
// mntp_step
// Token parser state and the per-character update. The result of the current
// character is combinational; state moves on when the character is consumed.
// ----------------------------------------------------------------------------
module mntp_step (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic [7:0]          ch,
  input  logic [7:0]          dflt_dur,
  input  logic [4:0]          dflt_oct,
  output mntp_pkg::mntp_res_t res
);
  import mntp_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE, PH_DUR, PH_LETTER, PH_SHARP, PH_OCT, PH_DOTS, PH_SKIP
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] dur_r, dur_nxt;
  logic [7:0] letter_r, letter_nxt;
  logic       sharp_r, sharp_nxt;
  logic [4:0] oct_r, oct_nxt;
  logic [4:0] dots_r, dots_nxt;
  logic       err_r, err_nxt;

  // character classes
  logic       is_num, is_upper, is_lower;
  logic [3:0] digit;
  logic [11:0] dur_acc;
  logic [8:0]  oct_acc;

  assign is_num   = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign is_upper = (ch >= CH_UP_A) && (ch <= CH_UP_Z);
  assign is_lower = (ch >= CH_LO_A) && (ch <= CH_LO_Z);
  assign digit    = 4'(ch - CH_ZERO);
  assign dur_acc  = {4'd0, dur_r} * 12'd10 + {8'd0, digit};
  assign oct_acc  = {4'd0, oct_r} * 9'd10 + {5'd0, digit};

  // token judgement on the held token
  logic [7:0] eff_dur;
  logic [4:0] eff_oct;
  logic       is_note, tok_ok;
  logic [8:0] semi_full;

  assign eff_dur   = (dur_r != 8'd0) ? dur_r : dflt_dur;
  assign eff_oct   = (oct_r != 5'd0) ? oct_r : dflt_oct;
  assign is_note   = (letter_r >= CH_UP_A) && (letter_r <= CH_UP_G);
  assign tok_ok    = (eff_dur != 8'd0) && (eff_dur <= DUR_MAX) &&
                     (is_note || (letter_r == CH_UP_P)) &&
                     (eff_oct <= OCT_MAX) && (dots_r <= DOTS_MAX);
  assign semi_full = {4'd0, eff_oct} * 9'(SEMIS_OCT)
                   + {5'd0, letter_offset(3'(letter_r - CH_UP_A))}
                   + {8'd0, sharp_r};

  // next state and result
  always_comb begin
    logic do_dur, do_oct, do_dots, do_close, clr;
    do_dur     = 1'b0;
    do_oct     = 1'b0;
    do_dots    = 1'b0;
    do_close   = 1'b0;
    clr        = 1'b0;
    phase_nxt  = phase_r;
    dur_nxt    = dur_r;
    letter_nxt = letter_r;
    sharp_nxt  = sharp_r;
    oct_nxt    = oct_r;
    dots_nxt   = dots_r;
    err_nxt    = err_r;
    res        = '0;

    if (err_r) begin
      // drop everything until the terminator
      if (ch == CH_NUL) begin
        err_nxt       = 1'b0;
        phase_nxt     = PH_IDLE;
        clr           = 1'b1;
        res.valid     = 1'b1;
        res.status    = ST_END;
        res.text_done = 1'b1;
      end
    end else begin
      case (phase_r)
        PH_IDLE: begin
          if (ch == CH_NUL) begin
            res.valid     = 1'b1;
            res.status    = ST_END;
            res.text_done = 1'b1;
          end else if (!((ch == CH_SPACE) || (ch == CH_TAB))) begin
            do_dur = 1'b1;
          end
        end
        PH_DUR:    do_dur = 1'b1;
        PH_LETTER: begin
          if ((ch == CH_HASH) || (ch == CH_UNDER)) begin
            sharp_nxt = 1'b1;
            phase_nxt = PH_SHARP;
          end else begin
            do_oct = 1'b1;
          end
        end
        PH_SHARP, PH_OCT: do_oct  = 1'b1;
        PH_DOTS:          do_dots = 1'b1;
        default: begin
          // skipping to the next comma
          if (ch == CH_COMMA) begin
            phase_nxt = PH_IDLE;
          end else if (ch == CH_NUL) begin
            phase_nxt     = PH_IDLE;
            res.valid     = 1'b1;
            res.status    = ST_END;
            res.text_done = 1'b1;
          end
        end
      endcase

      // duration digits or letter
      if (do_dur) begin
        if (is_num) begin
          dur_nxt   = (dur_acc > 12'd255) ? 8'hFF : dur_acc[7:0];
          phase_nxt = PH_DUR;
        end else if (is_upper || is_lower) begin
          letter_nxt = is_lower ? (ch - CASE_GAP) : ch;
          phase_nxt  = PH_LETTER;
        end else begin
          do_close = 1'b1;
        end
      end

      // octave digits
      if (do_oct) begin
        if (is_num) begin
          oct_nxt   = (oct_acc > 9'd31) ? 5'h1F : oct_acc[4:0];
          phase_nxt = PH_OCT;
        end else begin
          do_dots = 1'b1;
        end
      end

      // dots
      if (do_dots) begin
        if (ch == CH_DOT) begin
          if (dots_r != 5'h1F) dots_nxt = dots_r + 5'd1;
          phase_nxt = PH_DOTS;
        end else begin
          do_close = 1'b1;
        end
      end

      // token end
      if (do_close) begin
        clr           = 1'b1;
        res.valid     = 1'b1;
        res.text_done = (ch == CH_NUL);
        if (tok_ok) begin
          res.status      = ST_NOTE;
          res.semitone    = is_note ? semi_full[7:0] : PAUSE_SEMI;
          res.note_length = eff_dur;
          res.dot_count   = dots_r;
          phase_nxt = ((ch == CH_NUL) || (ch == CH_COMMA)) ? PH_IDLE : PH_SKIP;
        end else begin
          res.status = ST_BAD;
          if (ch != CH_NUL) err_nxt = 1'b1;
          phase_nxt = PH_IDLE;
        end
      end
    end

    if (clr) begin
      dur_nxt    = '0;
      letter_nxt = '0;
      sharp_nxt  = 1'b0;
      oct_nxt    = '0;
      dots_nxt   = '0;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      dur_r    <= '0;
      letter_r <= '0;
      sharp_r  <= 1'b0;
      oct_r    <= '0;
      dots_r   <= '0;
      err_r    <= 1'b0;
    end else if (adv) begin
      phase_r  <= phase_nxt;
      dur_r    <= dur_nxt;
      letter_r <= letter_nxt;
      sharp_r  <= sharp_nxt;
      oct_r    <= oct_nxt;
      dots_r   <= dots_nxt;
      err_r    <= err_nxt;
    end
  end

endmodule

[rtl/melody_note_token_parser_unit.sv]
// ----------------------------------------------------------------------------
// melody_note_token_parser_unit
// Parses comma separated note tokens one character a beat and returns a
// note, an error or an end-of-text beat.
//
//   channel | direction | ports
//   --------+-----------+--------------------------------------------------
//   in      | sink      | in_valid, in_ready, in_character
//   out     | source    | out_valid, out_ready, out_status, out_semitone,
//           |           | out_note_length, out_dot_count, out_text_done
//   cfg     | sink      | cfg_wr_en, cfg_index, cfg_data
//
// One character is taken every cycle unless a held result stalls the input;
// its result passes from the input register through the parser into the
// result register, from which it is handed over.
// Reset returns the parser to idle and the defaults to duration 4, octave 5.
// A held result stalls the input register only when the next character also
// gives a result; characters that give none keep flowing.
// ----------------------------------------------------------------------------
module melody_note_token_parser_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_character,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_status,
  output logic [7:0] out_semitone,
  output logic [7:0] out_note_length,
  output logic [4:0] out_dot_count,
  output logic       out_text_done,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import mntp_pkg::*;

  logic       s1_valid_r;
  logic [7:0] s1_char_r;
  logic [7:0] dflt_dur_r;
  logic [4:0] dflt_oct_r;
  logic       out_valid_r;
  mntp_res_t  out_res_r;
  mntp_res_t  res;
  logic       adv;

  // parser moves on when its result, if any, has room
  assign adv      = s1_valid_r && (!res.valid || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  mntp_step u_step (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .ch       (s1_char_r),
    .dflt_dur (dflt_dur_r),
    .dflt_oct (dflt_oct_r),
    .res      (res)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dflt_dur_r <= 8'd4;
      dflt_oct_r <= 5'd5;
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_DFLT_DUR) dflt_dur_r <= cfg_data;
      if (cfg_index == CFG_DFLT_OCT) dflt_oct_r <= cfg_data[4:0];
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) s1_char_r <= in_character;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.valid) out_res_r <= res;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_res_r.status;
  assign out_semitone    = out_res_r.semitone;
  assign out_note_length = out_res_r.note_length;
  assign out_dot_count   = out_res_r.dot_count;
  assign out_text_done   = out_res_r.text_done;

endmodule
